// ----- hdl/lfba_pkg.sv -----
// lfba_pkg: shared constants and types for the linked-list fifo with bitmap allocator
// no dependencies; used by lfba_ram and linked_fifo_bitmap_alloc
package lfba_pkg;

    localparam int NODES_DEF     = 64;
    localparam int ITEM_BITS_DEF = 32;
    localparam int MAP_WORD_BITS = 32;
    localparam int BIT_IDX_W     = 5;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_SCAN    = 4'b0010,
        ST_RD_LINK = 4'b0100,
        ST_RD_ITEM = 4'b1000
    } lfba_state_t;

endpackage

// ----- hdl/linked_fifo_bitmap_alloc.sv -----
// linked_fifo_bitmap_alloc: bounded fifo kept as a linked list over a node pool
// depends on lfba_pkg and lfba_ram (link store and item store)
//
// A write takes the lowest free node from a usage bitmap of NODES/32 words,
// checked one word per cycle from word 0 until a word with a free bit turns
// up. A read first fetches the head's link from the link ram, then fetches
// the item from the item ram. A write to a full pool or a read of an empty
// queue is answered straight away with a refusal status. One item is worked
// on at a time; a new item is taken once the previous result has been taken
// or is being taken. Capacity is NODES-1 items. The ram contents need no
// clearing after reset.
module linked_fifo_bitmap_alloc #(
    parameter int NODES     = lfba_pkg::NODES_DEF,
    parameter int ITEM_BITS = lfba_pkg::ITEM_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [31:0] data_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [31:0] data_out,
    output logic [5:0]  items_held
);

    import lfba_pkg::*;

    localparam int WORDS  = NODES / MAP_WORD_BITS;
    localparam int NODE_W = $clog2(NODES);
    localparam int MAP_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CNT_W  = $clog2(NODES);

    lfba_state_t state_reg, state_next;

    logic [MAP_WORD_BITS-1:0] usage_reg [WORDS];
    logic [MAP_W-1:0]         scan_reg, scan_next;
    logic [NODE_W-1:0]        head_reg, head_next;
    logic [NODE_W-1:0]        tail_reg, tail_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [ITEM_BITS-1:0]     item_reg, item_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  status_reg, status_next;
    logic [31:0] data_out_reg, data_out_next;

    logic                     accept;
    logic                     pool_full;
    logic                     queue_empty;
    logic [MAP_WORD_BITS-1:0] scan_word;
    logic [MAP_WORD_BITS-1:0] free_bits;
    logic [MAP_WORD_BITS-1:0] lowest_free;
    logic [BIT_IDX_W-1:0]     bit_idx;
    logic                     word_has_free;
    logic [NODE_W-1:0]        found_node;

    logic                     set_bit;
    logic                     clr_bit;
    logic [MAP_W-1:0]         clr_word;
    logic [BIT_IDX_W-1:0]     clr_idx;

    logic                     store_we;
    logic [NODE_W-1:0]        link_rdata;
    logic [ITEM_BITS-1:0]     item_rdata;

    assign in_ready    = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept      = in_valid && in_ready;
    assign pool_full   = (count_reg == CNT_W'(NODES - 1));
    assign queue_empty = (count_reg == '0);

    // lowest zero bit of the word under scan
    assign scan_word     = usage_reg[scan_reg];
    assign free_bits     = ~scan_word;
    assign lowest_free   = free_bits & (~free_bits + MAP_WORD_BITS'(1));
    assign word_has_free = (free_bits != '0);

    always_comb
    begin
        bit_idx = '0;
        for (int i = 0; i < MAP_WORD_BITS; i++)
        begin
            if (lowest_free[i])
            begin
                bit_idx = bit_idx | BIT_IDX_W'(i);
            end
        end
    end

    assign found_node = NODE_W'({scan_reg, bit_idx});
    assign clr_word   = MAP_W'(head_reg >> BIT_IDX_W);
    assign clr_idx    = BIT_IDX_W'(head_reg);

    always_comb
    begin
        state_next     = state_reg;
        scan_next      = scan_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        item_next      = item_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        data_out_next  = data_out_reg;
        set_bit        = 1'b0;
        clr_bit        = 1'b0;
        store_we       = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next = ITEM_BITS'(data_in);
                    scan_next = '0;
                    if (op == OP_WRITE)
                    begin
                        if (pool_full)
                        begin
                            out_valid_next = 1'b1;
                            status_next    = STATUS_FULL;
                            data_out_next  = '0;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    else
                    begin
                        if (queue_empty)
                        begin
                            out_valid_next = 1'b1;
                            status_next    = STATUS_EMPTY;
                            data_out_next  = '0;
                        end
                        else
                        begin
                            state_next = ST_RD_LINK;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (word_has_free)
                begin
                    set_bit        = 1'b1;
                    store_we       = 1'b1;
                    tail_next      = found_node;
                    count_next     = count_reg + CNT_W'(1);
                    out_valid_next = 1'b1;
                    status_next    = STATUS_DONE;
                    data_out_next  = '0;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + MAP_W'(1);
                end
            end
            ST_RD_LINK:
            begin
                clr_bit    = 1'b1;
                head_next  = link_rdata;
                count_next = count_reg - CNT_W'(1);
                state_next = ST_RD_ITEM;
            end
            ST_RD_ITEM:
            begin
                out_valid_next = 1'b1;
                status_next    = STATUS_DONE;
                data_out_next  = 32'(item_rdata);
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int w = 0; w < WORDS; w++)
            begin
                usage_reg[w] <= (w == 0) ? MAP_WORD_BITS'(1) : '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (set_bit)
            begin
                usage_reg[scan_reg] <= scan_word | lowest_free;
            end
            else if (clr_bit)
            begin
                usage_reg[clr_word][clr_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        status_reg   <= status_next;
        data_out_reg <= data_out_next;
    end

    // link store: written at the tail, read at the head
    lfba_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODES)
    ) u_link_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (tail_reg),
        .wdata (found_node),
        .raddr (head_reg),
        .rdata (link_rdata)
    );

    // item store: written at the new node, read at the head's successor
    lfba_ram #(
        .WIDTH (ITEM_BITS),
        .DEPTH (NODES)
    ) u_item_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (found_node),
        .wdata (item_reg),
        .raddr (link_rdata),
        .rdata (item_rdata)
    );

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign data_out   = data_out_reg;
    assign items_held = 6'(count_reg);

endmodule

// ----- hdl/lfba_ram.sv -----
// lfba_ram: generic single write port, single read port ram with registered read
// depends on lfba_pkg only for its parameter defaults; no reset on contents
module lfba_ram #(
    parameter int WIDTH = lfba_pkg::ITEM_BITS_DEF,
    parameter int DEPTH = lfba_pkg::NODES_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
